// ===== rtl/core/mms_pkg.sv =====
// ----------------------------------------------------------------------------
// mms_pkg: modulation matrix sum shared definitions
// Sizes, codes, word formats and derived widths used by every file of the
// modulation matrix summer.
// ----------------------------------------------------------------------------
package mms_pkg;

   localparam int NUM_SLOTS        = 16;
   localparam int NUM_SOURCES      = 8;
   localparam int NUM_DESTINATIONS = 32;

   localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SRC_IDX_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   // Field widths of the request and response words.
   localparam int FUNC_W   = 2;
   localparam int INDEX_W  = 4;
   localparam int SOURCE_W = 4;
   localparam int DEST_W   = 5;
   localparam int AMOUNT_W = 16;
   localparam int LEVEL_W  = 16;
   localparam int OUT_W    = 36;

   // Arithmetic widths: mapped level, product and accumulator.
   localparam int LVL_W  = LEVEL_W + 1;
   localparam int PROD_W = LVL_W + AMOUNT_W;
   localparam int ACC_W  = PROD_W + SLOT_IDX_W + 1;

   localparam logic [FUNC_W-1:0] FUNC_WR_SLOT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WR_LEVEL = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY    = 2'd2;

   localparam logic [SOURCE_W-1:0] NO_SOURCE = 4'd8;
   localparam logic [LEVEL_W-1:0]  LEVEL_ONE = 16'd32768;

   localparam logic signed [OUT_W-1:0] OUT_MAX = 36'sd17179869183;
   localparam logic signed [OUT_W-1:0] OUT_MIN = -36'sd17179869184;

   typedef struct packed {
      logic [FUNC_W-1:0]          func;
      logic [INDEX_W-1:0]         index;
      logic                       slot_enabled;
      logic [SOURCE_W-1:0]        slot_source;
      logic [DEST_W-1:0]          destination;
      logic                       slot_bipolar;
      logic signed [AMOUNT_W-1:0] slot_amount;
      logic [LEVEL_W-1:0]         source_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] total_modulation;
   } rsp_payload_type;

   typedef struct packed {
      logic                       enabled;
      logic [SOURCE_W-1:0]        source;
      logic [DEST_W-1:0]          destination;
      logic                       bipolar;
      logic signed [AMOUNT_W-1:0] amount;
   } slot_type;

   typedef struct packed {
      logic                  slot_we;
      logic [SLOT_IDX_W-1:0] slot_idx;
      slot_type              slot;
      logic                  level_we;
      logic [SRC_IDX_W-1:0]  level_idx;
      logic [LEVEL_W-1:0]    level;
   } tbl_wr_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic hit;
      logic bipolar;
   } mac_ctrl_type;

endpackage

// ===== rtl/core/mms_req_if.sv =====
// ----------------------------------------------------------------------------
// mms_req_if: request channel
// Valid/ready channel that carries one request word per handshake.
// ----------------------------------------------------------------------------
interface mms_req_if;
   import mms_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

// ===== rtl/core/mms_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mms_rsp_if: response channel
// Valid/ready channel that carries one response word per handshake.
// ----------------------------------------------------------------------------
interface mms_rsp_if;
   import mms_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

// ===== rtl/core/mms_tables.sv =====
// ----------------------------------------------------------------------------
// mms_tables: routing slots and source levels
// Holds the slot table and the current source levels, takes one slot write and
// one level write per cycle and reads the slot under the walk counter together with its level.
// ----------------------------------------------------------------------------
module mms_tables (
   input  logic                           clock,
   input  logic                           reset,
   input  mms_pkg::tbl_wr_type            wr,
   input  logic [mms_pkg::SLOT_IDX_W-1:0] rd_idx,
   output mms_pkg::slot_type              rd_slot,
   output logic [mms_pkg::LEVEL_W-1:0]    rd_level
);
   import mms_pkg::*;

   slot_type           slot_ff  [NUM_SLOTS];
   logic [LEVEL_W-1:0] level_ff [NUM_SOURCES];

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '{default: '0};
         level_ff <= '{default: '0};
      end else begin
         if (wr.slot_we) begin
            slot_ff[wr.slot_idx] <= wr.slot;
         end
         if (wr.level_we) begin
            level_ff[wr.level_idx] <= wr.level;
         end
      end
   end

   // The level lookup aliases for an invalid source code; the sequencer
   // drops such a slot, so the value read then does not matter.
   assign rd_slot  = slot_ff[rd_idx];
   assign rd_level = level_ff[SRC_IDX_W'(rd_slot.source)];

endmodule

// ===== rtl/core/mms_mac.sv =====
// ----------------------------------------------------------------------------
// mms_mac: shared multiply-accumulate unit
// Maps a level to bipolar form when asked, multiplies it by the slot amount
// and adds the product to the running sum, one slot per cycle in two stages.
// ----------------------------------------------------------------------------
module mms_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  mms_pkg::mac_ctrl_type             ctrl,
   input  logic [mms_pkg::LEVEL_W-1:0]       level,
   input  logic signed [mms_pkg::AMOUNT_W-1:0] amount,
   output logic                              busy,
   output logic signed [mms_pkg::ACC_W-1:0]  acc
);
   import mms_pkg::*;

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_hit_ff;
   logic signed [LVL_W-1:0]    s1_lvl_ff, s1_lvl_in;
   logic signed [AMOUNT_W-1:0] s1_amt_ff;
   logic                       s2_valid_ff;
   logic signed [PROD_W-1:0]   s2_prod_ff, s2_prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [LVL_W:0]      twice_lvl;

   always_comb begin
      // 2v - 1.0 in Q1.15 needs one guard bit before it lands in range.
      twice_lvl   = $signed({1'b0, level, 1'b0}) - $signed((LVL_W + 1)'(LEVEL_ONE));
      s1_lvl_in   = ctrl.bipolar ? twice_lvl[LVL_W-1:0] : $signed({1'b0, level});
      s1_valid_in = ctrl.step;
      s2_prod_in  = s1_lvl_ff * s1_amt_ff;
      if (!s1_hit_ff) begin
         s2_prod_in = '0;
      end
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (s2_valid_ff) begin
         acc_in = acc_ff + ACC_W'(s2_prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         acc_ff      <= acc_in;
      end
      s1_hit_ff  <= ctrl.hit;
      s1_lvl_ff  <= s1_lvl_in;
      s1_amt_ff  <= amount;
      s2_prod_ff <= s2_prod_in;
   end

   assign busy = s1_valid_ff | s2_valid_ff;
   assign acc  = acc_ff;

endmodule

// ===== rtl/core/modulation_matrix_sum_top.sv =====
// ----------------------------------------------------------------------------
// modulation_matrix_sum_top: modulation matrix summer
// Stores routing slots and source levels and answers a destination query
// with the sum of all scaled sources routed to it.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Word                 Words per request
//   req_chan   in         func, slot, level    one
//   rsp_chan   out        total_modulation     one per query, none per write
//
// A slot or level write is stored in its table on acceptance. A query walks the slots
// through the one shared multiply-accumulate unit, one slot a cycle, then
// drains its two stages; no new word is taken until its sum is registered.
// The response sits in an output register, so a stalled response only holds
// the block once a second query has walked its slots. Reset is synchronous
// and clears both tables.
// ----------------------------------------------------------------------------
module modulation_matrix_sum_top (
   input logic   clock,
   input logic   reset,
   mms_req_if.sink   req_chan,
   mms_rsp_if.source rsp_chan
);
   import mms_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN
   } state_type;

   state_type               state_ff, state_in;
   logic [SLOT_IDX_W-1:0]   cnt_ff, cnt_in;
   logic [DEST_W-1:0]       qdest_ff, qdest_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_data_ff, rsp_data_in;

   req_payload_type         req;
   logic                    accept;
   logic [LEVEL_W-1:0]      sat_level;
   tbl_wr_type              tbl_wr;
   slot_type                rd_slot;
   logic [LEVEL_W-1:0]      rd_level;
   logic                    src_ok;
   logic                    qdest_ok;
   mac_ctrl_type            mac_ctrl;
   logic                    mac_busy;
   logic signed [ACC_W-1:0] acc;
   logic signed [OUT_W-1:0] acc_sat;

   assign req    = req_chan.payload;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      sat_level          = (req.source_value > LEVEL_ONE) ? LEVEL_ONE : req.source_value;
      tbl_wr.slot_we     = accept && (req.func == FUNC_WR_SLOT)
                           && (32'(req.index) < NUM_SLOTS);
      tbl_wr.slot_idx    = SLOT_IDX_W'(req.index);
      tbl_wr.slot        = '{enabled:     req.slot_enabled,
                             source:      req.slot_source,
                             destination: req.destination,
                             bipolar:     req.slot_bipolar,
                             amount:      req.slot_amount};
      tbl_wr.level_we    = accept && (req.func == FUNC_WR_LEVEL)
                           && (32'(req.index) < NUM_SOURCES);
      tbl_wr.level_idx   = SRC_IDX_W'(req.index);
      tbl_wr.level       = sat_level;
   end

   mms_tables u_tables (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd_idx   (cnt_ff),
      .rd_slot  (rd_slot),
      .rd_level (rd_level)
   );

   always_comb begin
      src_ok   = (rd_slot.source != NO_SOURCE) && (32'(rd_slot.source) < NUM_SOURCES);
      qdest_ok = 32'(qdest_ff) < NUM_DESTINATIONS;
      mac_ctrl.clear   = accept && (req.func == FUNC_QUERY);
      mac_ctrl.step    = (state_ff == ST_WALK);
      mac_ctrl.hit     = rd_slot.enabled && src_ok && qdest_ok
                         && (rd_slot.destination == qdest_ff);
      mac_ctrl.bipolar = rd_slot.bipolar;
   end

   mms_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .level  (rd_level),
      .amount (rd_slot.amount),
      .busy   (mac_busy),
      .acc    (acc)
   );

   always_comb begin
      if (acc > ACC_W'(OUT_MAX)) begin
         acc_sat = OUT_MAX;
      end else if (acc < ACC_W'(OUT_MIN)) begin
         acc_sat = OUT_MIN;
      end else begin
         acc_sat = acc[OUT_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      qdest_in     = qdest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req.func == FUNC_QUERY)) begin
               qdest_in = req.destination;
               cnt_in   = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SLOT_IDX_W'(NUM_SLOTS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The sum is final once both unit stages are empty; it waits
            // here also while an older response is still unclaimed.
            if (!mac_busy && !rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_sat;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      qdest_ff    <= qdest_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready                    = (state_ff == ST_IDLE);
   assign rsp_chan.valid                    = rsp_valid_ff;
   assign rsp_chan.payload.total_modulation = rsp_data_ff;

endmodule
